// ===== rtl/spm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sparse polynomial multiplier package
// Shared widths, beat types, stored term type, merge table entry type and sequencer states.
// ----------------------------------------------------------------------------
package spm_pkg;

	localparam int MAX_TERMS_DEF = 8;
	localparam int COEF_W        = 16;
	localparam int EXP_W         = 8;
	localparam int PEXP_W        = 9;
	localparam int PROD_W        = 32;
	localparam int SUM_W         = 38;

	typedef struct packed {
		logic                     cmd;
		logic signed [COEF_W-1:0] coefficient;
		logic [EXP_W-1:0]         exponent;
		logic                     last_term;
	} term_beat_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] product_coefficient;
		logic [PEXP_W-1:0]       product_exponent;
		logic                    is_term;
		logic                    last_result;
	} result_beat_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] coefficient;
		logic [EXP_W-1:0]         exponent;
	} term_t;

	typedef struct packed {
		logic [PEXP_W-1:0]       exp;
		logic signed [SUM_W-1:0] sum;
	} merge_entry_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_FETCH,
		ST_MULT,
		ST_LOOKUP,
		ST_UPDATE,
		ST_EMIT_RD,
		ST_EMIT_CHK,
		ST_EMPTY
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/spm_term_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Term store
// Holds the terms of both polynomials, with one write port shared by both
// and one registered read port for each polynomial.
// ----------------------------------------------------------------------------
module spm_term_store #(
	parameter int MAX_TERMS = spm_pkg::MAX_TERMS_DEF
) (
	input  wire logic                                     clk,
	input  wire logic                                     wr_en,
	input  wire logic                                     wr_second,
	input  wire logic [((MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1)-1:0] wr_idx,
	input  wire spm_pkg::term_t                           wr_term,
	input  wire logic                                     rd_en,
	input  wire logic [((MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1)-1:0] rd_first_idx,
	input  wire logic [((MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1)-1:0] rd_second_idx,
	output spm_pkg::term_t                                first_term,
	output spm_pkg::term_t                                second_term
);

	spm_pkg::term_t first_mem  [MAX_TERMS];
	spm_pkg::term_t second_mem [MAX_TERMS];
	spm_pkg::term_t first_q;
	spm_pkg::term_t second_q;

	always_ff @(posedge clk) begin
		if (wr_en && !wr_second) begin
			first_mem[wr_idx] <= wr_term;
		end
		if (wr_en && wr_second) begin
			second_mem[wr_idx] <= wr_term;
		end
		if (rd_en) begin
			first_q  <= first_mem[rd_first_idx];
			second_q <= second_mem[rd_second_idx];
		end
	end

	assign first_term  = first_q;
	assign second_term = second_q;

endmodule
`default_nettype wire

// ===== rtl/spm_merge_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Merge table
// Entry memory of merged (exponent, sum) pairs in order of first appearance,
// and a directory that maps an exponent to its candidate entry slot.
// ----------------------------------------------------------------------------
module spm_merge_table #(
	parameter int DEPTH = spm_pkg::MAX_TERMS_DEF * spm_pkg::MAX_TERMS_DEF
) (
	input  wire logic                                         clk,
	input  wire logic                                         dir_rd_en,
	input  wire logic [spm_pkg::PEXP_W-1:0]                   dir_rd_exp,
	output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]      dir_slot,
	input  wire logic                                         dir_wr_en,
	input  wire logic [spm_pkg::PEXP_W-1:0]                   dir_wr_exp,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] dir_wr_slot,
	input  wire logic                                         ent_rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] ent_rd_slot,
	output spm_pkg::merge_entry_t                             ent_rd_data,
	input  wire logic                                         ent_wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] ent_wr_slot,
	input  wire spm_pkg::merge_entry_t                        ent_wr_data
);

	localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [SLOT_W-1:0]     dir_mem [2**spm_pkg::PEXP_W];
	spm_pkg::merge_entry_t ent_mem [DEPTH];
	logic [SLOT_W-1:0]     dir_q;
	spm_pkg::merge_entry_t ent_q;

	always_ff @(posedge clk) begin
		if (dir_wr_en) begin
			dir_mem[dir_wr_exp] <= dir_wr_slot;
		end
		if (dir_rd_en) begin
			dir_q <= dir_mem[dir_rd_exp];
		end
	end

	always_ff @(posedge clk) begin
		if (ent_wr_en) begin
			ent_mem[ent_wr_slot] <= ent_wr_data;
		end
		if (ent_rd_en) begin
			ent_q <= ent_mem[ent_rd_slot];
		end
	end

	assign dir_slot    = dir_q;
	assign ent_rd_data = ent_q;

endmodule
`default_nettype wire

// ===== rtl/sparse_polynomial_multiply.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sparse polynomial multiplier
// Loads two sparse polynomials term by term and streams out their product,
// one beat per distinct exponent with a nonzero merged coefficient.
//
// Term channel: each beat carries one (coefficient, exponent) term; cmd 0
// goes to the first polynomial, cmd 1 to the second. Each polynomial keeps
// at most MAX_TERMS terms and drops the rest. Terms are taken one per cycle.
// A cmd 1 beat with last_term set starts the product; no term is taken until
// the last result beat has been loaded into the output register.
// Products are formed first term by second term; each passes through the
// MULT, LOOKUP and UPDATE states: a multiply and exponent directory read,
// then the read, modify and write of the merge table entry. Emission reads
// table entries in turn through EMIT_RD and EMIT_CHK and skips entries
// whose sum is zero.
// If nothing remains, a single beat with is_term 0 and last_result 1 goes out.
// Result channel: a single output register; a stalled receiver holds the
// sequencer in the emit phase. Reset clears all counts and the sequencer;
// the memories need no clearing.
// ----------------------------------------------------------------------------
module sparse_polynomial_multiply #(
	parameter int MAX_TERMS = spm_pkg::MAX_TERMS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  term_valid,
	output logic                       term_ready,
	input  wire spm_pkg::term_beat_t   term,
	output logic                       result_valid,
	input  wire logic                  result_ready,
	output spm_pkg::result_beat_t      result
);

	localparam int IDX_W  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CNT_W  = $clog2(MAX_TERMS + 1);
	localparam int MDEPTH = MAX_TERMS * MAX_TERMS;
	localparam int SLOT_W = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
	localparam int MCNT_W = $clog2(MDEPTH + 1);
	localparam int PEXP_W = spm_pkg::PEXP_W;
	localparam int SUM_W  = spm_pkg::SUM_W;
	localparam int PROD_W = spm_pkg::PROD_W;

	spm_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0]  fc_q, fc_d, sc_q, sc_d;
	logic [IDX_W-1:0]  i_q, i_d, j_q, j_d;
	logic [MCNT_W-1:0] mcnt_q, mcnt_d, nz_q, nz_d, emit_q, emit_d;
	logic [SLOT_W-1:0] k_q, k_d;

	logic signed [PROD_W-1:0] prod_s1;
	logic [PEXP_W-1:0]        pexp_s1;

	logic                  ts_wr_en;
	logic [IDX_W-1:0]      ts_wr_idx;
	spm_pkg::term_t        ts_wr_term;
	logic                  ts_rd_en;
	logic [IDX_W-1:0]      ts_rd_i, ts_rd_j;
	spm_pkg::term_t        first_term, second_term;

	logic                  dir_rd_en;
	logic [PEXP_W-1:0]     dir_rd_exp;
	logic [SLOT_W-1:0]     dir_slot;
	logic                  dir_wr_en;
	logic                  ent_rd_en;
	logic [SLOT_W-1:0]     ent_rd_slot;
	spm_pkg::merge_entry_t ent_rd_data;
	logic                  ent_wr_en;
	logic [SLOT_W-1:0]     ent_wr_slot;
	spm_pkg::merge_entry_t ent_wr_data;

	logic                    hit;
	logic signed [SUM_W-1:0] prod_ext;
	logic signed [SUM_W-1:0] new_sum;
	logic                    last_i, last_j, last_emit;

	logic                  result_valid_q;
	spm_pkg::result_beat_t result_q, out_d;
	logic                  out_free, out_load;

	spm_term_store #(
		.MAX_TERMS(MAX_TERMS)
	) u_term_store (
		.clk          (clk),
		.wr_en        (ts_wr_en),
		.wr_second    (term.cmd),
		.wr_idx       (ts_wr_idx),
		.wr_term      (ts_wr_term),
		.rd_en        (ts_rd_en),
		.rd_first_idx (ts_rd_i),
		.rd_second_idx(ts_rd_j),
		.first_term   (first_term),
		.second_term  (second_term)
	);

	spm_merge_table #(
		.DEPTH(MDEPTH)
	) u_merge_table (
		.clk        (clk),
		.dir_rd_en  (dir_rd_en),
		.dir_rd_exp (dir_rd_exp),
		.dir_slot   (dir_slot),
		.dir_wr_en  (dir_wr_en),
		.dir_wr_exp (pexp_s1),
		.dir_wr_slot(mcnt_q[SLOT_W-1:0]),
		.ent_rd_en  (ent_rd_en),
		.ent_rd_slot(ent_rd_slot),
		.ent_rd_data(ent_rd_data),
		.ent_wr_en  (ent_wr_en),
		.ent_wr_slot(ent_wr_slot),
		.ent_wr_data(ent_wr_data)
	);

	assign ts_wr_idx  = term.cmd ? sc_q[IDX_W-1:0] : fc_q[IDX_W-1:0];
	assign ts_wr_term = '{coefficient: term.coefficient, exponent: term.exponent};
	assign dir_rd_exp = PEXP_W'(first_term.exponent) + PEXP_W'(second_term.exponent);

	assign prod_ext  = {{(SUM_W - PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
	assign hit       = (MCNT_W'(dir_slot) < mcnt_q) && (ent_rd_data.exp == pexp_s1);
	assign last_i    = (CNT_W'(i_q) + CNT_W'(1)) == fc_q;
	assign last_j    = (CNT_W'(j_q) + CNT_W'(1)) == sc_q;
	assign last_emit = (emit_q + MCNT_W'(1)) == nz_q;
	assign out_free  = !result_valid_q || result_ready;

	always_comb begin
		state_d     = state_q;
		fc_d        = fc_q;
		sc_d        = sc_q;
		i_d         = i_q;
		j_d         = j_q;
		mcnt_d      = mcnt_q;
		nz_d        = nz_q;
		k_d         = k_q;
		emit_d      = emit_q;
		term_ready  = 1'b0;
		ts_wr_en    = 1'b0;
		ts_rd_en    = 1'b0;
		ts_rd_i     = i_q;
		ts_rd_j     = j_q;
		dir_rd_en   = 1'b0;
		dir_wr_en   = 1'b0;
		ent_rd_en   = 1'b0;
		ent_rd_slot = dir_slot;
		ent_wr_en   = 1'b0;
		ent_wr_slot = dir_slot;
		new_sum     = prod_ext;
		out_load    = 1'b0;
		out_d       = result_q;
		unique case (state_q)
			spm_pkg::ST_LOAD: begin
				term_ready = 1'b1;
				if (term_valid) begin
					if (!term.cmd) begin
						if (fc_q < CNT_W'(MAX_TERMS)) begin
							ts_wr_en = 1'b1;
							fc_d     = fc_q + CNT_W'(1);
						end
					end else begin
						if (sc_q < CNT_W'(MAX_TERMS)) begin
							ts_wr_en = 1'b1;
							sc_d     = sc_q + CNT_W'(1);
						end
						if (term.last_term) begin
							i_d    = '0;
							j_d    = '0;
							mcnt_d = '0;
							nz_d   = '0;
							k_d    = '0;
							emit_d = '0;
							state_d = (fc_q == '0) ? spm_pkg::ST_EMPTY : spm_pkg::ST_FETCH;
						end
					end
				end
			end
			spm_pkg::ST_FETCH: begin
				ts_rd_en = 1'b1;
				state_d  = spm_pkg::ST_MULT;
			end
			spm_pkg::ST_MULT: begin
				dir_rd_en = 1'b1;
				state_d   = spm_pkg::ST_LOOKUP;
			end
			spm_pkg::ST_LOOKUP: begin
				ent_rd_en = 1'b1;
				state_d   = spm_pkg::ST_UPDATE;
			end
			spm_pkg::ST_UPDATE: begin
				ent_wr_en = 1'b1;
				if (hit) begin
					new_sum     = ent_rd_data.sum + prod_ext;
					ent_wr_slot = dir_slot;
					if ((new_sum != '0) && (ent_rd_data.sum == '0)) begin
						nz_d = nz_q + MCNT_W'(1);
					end else if ((new_sum == '0) && (ent_rd_data.sum != '0)) begin
						nz_d = nz_q - MCNT_W'(1);
					end
				end else begin
					ent_wr_slot = mcnt_q[SLOT_W-1:0];
					dir_wr_en   = 1'b1;
					mcnt_d      = mcnt_q + MCNT_W'(1);
					if (prod_ext != '0) begin
						nz_d = nz_q + MCNT_W'(1);
					end
				end
				if (last_j) begin
					j_d = '0;
					i_d = i_q + IDX_W'(1);
				end else begin
					j_d = j_q + IDX_W'(1);
				end
				ts_rd_en = 1'b1;
				ts_rd_i  = i_d;
				ts_rd_j  = j_d;
				if (last_i && last_j) begin
					k_d     = '0;
					state_d = (nz_d == '0) ? spm_pkg::ST_EMPTY : spm_pkg::ST_EMIT_RD;
				end else begin
					state_d = spm_pkg::ST_MULT;
				end
			end
			spm_pkg::ST_EMIT_RD: begin
				ent_rd_en   = 1'b1;
				ent_rd_slot = k_q;
				state_d     = spm_pkg::ST_EMIT_CHK;
			end
			spm_pkg::ST_EMIT_CHK: begin
				if (ent_rd_data.sum == '0) begin
					k_d     = k_q + SLOT_W'(1);
					state_d = spm_pkg::ST_EMIT_RD;
				end else if (out_free) begin
					out_load = 1'b1;
					out_d    = '{product_coefficient: ent_rd_data.sum,
						product_exponent: ent_rd_data.exp,
						is_term: 1'b1, last_result: last_emit};
					emit_d   = emit_q + MCNT_W'(1);
					k_d      = k_q + SLOT_W'(1);
					if (last_emit) begin
						fc_d    = '0;
						sc_d    = '0;
						state_d = spm_pkg::ST_LOAD;
					end else begin
						state_d = spm_pkg::ST_EMIT_RD;
					end
				end
			end
			spm_pkg::ST_EMPTY: begin
				if (out_free) begin
					out_load = 1'b1;
					out_d    = '{product_coefficient: '0, product_exponent: '0,
						is_term: 1'b0, last_result: 1'b1};
					fc_d     = '0;
					sc_d     = '0;
					state_d  = spm_pkg::ST_LOAD;
				end
			end
			default: begin
				state_d = spm_pkg::ST_LOAD;
			end
		endcase
	end

	assign ent_wr_data = '{exp: pexp_s1, sum: new_sum};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= spm_pkg::ST_LOAD;
			fc_q           <= '0;
			sc_q           <= '0;
			i_q            <= '0;
			j_q            <= '0;
			mcnt_q         <= '0;
			nz_q           <= '0;
			k_q            <= '0;
			emit_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fc_q    <= fc_d;
			sc_q    <= sc_d;
			i_q     <= i_d;
			j_q     <= j_d;
			mcnt_q  <= mcnt_d;
			nz_q    <= nz_d;
			k_q     <= k_d;
			emit_q  <= emit_d;
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == spm_pkg::ST_MULT) begin
			prod_s1 <= first_term.coefficient * second_term.coefficient;
			pexp_s1 <= dir_rd_exp;
		end
		if (out_load) begin
			result_q <= out_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_nz_within_table: assert property (@(posedge clk) disable iff (!arst_n)
		nz_q <= mcnt_q)
		else $error("Nonzero entry count exceeds table fill.");

	a_table_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == spm_pkg::ST_UPDATE |-> mcnt_q < MCNT_W'(MDEPTH))
		else $error("Merge table full before the last product.");

	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == spm_pkg::ST_EMIT_CHK |-> emit_q < nz_q)
		else $error("Emission ran past the last nonzero entry.");

	a_empty_only_when_zero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == spm_pkg::ST_EMPTY |-> nz_q == '0)
		else $error("Empty product marker with nonzero entries.");

	a_marker_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !result_q.is_term |-> result_q.last_result)
		else $error("Empty product marker without last_result.");

endmodule
`default_nettype wire

// ===== tb/sv/sparse_polynomial_multiply_tb.sv =====
// ----------------------------------------------------------------------------
// Sparse polynomial multiplier testbench
// Feeds term beats from a short directed table, then random polynomial pairs,
// takes expected beats from the table or a behavioral model of the multiplier,
// and checks each result beat field by field under random idling and stalls.
// ----------------------------------------------------------------------------
module sparse_polynomial_multiply_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int   TERM_CAP    = spm_pkg::MAX_TERMS_DEF;
	localparam logic CMD_FIRST   = 1'b0;
	localparam logic CMD_SECOND  = 1'b1;
	localparam int   IDLE_PCT    = 16;
	localparam int   HOLD_CYCLES = 300;
	localparam int   STALL_LIMIT = 4000;
	localparam int   RANDOM_BEATS = 180;

	typedef struct {
		spm_pkg::term_beat_t   beat;
		int                    reps;
		bit                    typed;
		spm_pkg::result_beat_t want;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  term_valid;
	logic                  term_ready;
	spm_pkg::term_beat_t   term;
	logic                  result_valid;
	logic                  result_ready;
	spm_pkg::result_beat_t result;

	spm_pkg::term_t        first_terms[TERM_CAP];
	spm_pkg::term_t        second_terms[TERM_CAP];
	int                    first_n;
	int                    second_n;
	spm_pkg::result_beat_t product_due[$];
	int                    counted_beats;
	int                    errors;
	bit                    calm;
	bit                    hold_results;

	stim_row_t stim_table[11] = '{
		'{{CMD_SECOND, 16'sd0, 8'd0, 1'b1}, 1, 1'b1, {38'sd0, 9'd0, 1'b0, 1'b1}},
		'{{CMD_FIRST, 16'sd32767, 8'd255, 1'b1}, 1, 1'b0, '0},
		'{{CMD_SECOND, 16'sd32767, 8'd255, 1'b1}, 1, 1'b1,
			{38'sd1073676289, 9'd510, 1'b1, 1'b1}},
		'{{CMD_SECOND, 16'sd1, 8'd1, 1'b0}, 1, 1'b0, '0},
		'{{CMD_FIRST, 16'sd1, 8'd0, 1'b0}, 1, 1'b0, '0},
		'{{CMD_FIRST, 16'sd1, 8'd1, 1'b1}, 1, 1'b0, '0},
		'{{CMD_SECOND, 16'hFFFF, 8'd0, 1'b1}, 1, 1'b0, '0},
		'{{CMD_FIRST, 16'h8000, 8'd0, 1'b0}, 8, 1'b0, '0},
		'{{CMD_FIRST, 16'h8000, 8'd0, 1'b1}, 1, 1'b0, '0},
		'{{CMD_SECOND, 16'h8000, 8'd0, 1'b0}, 8, 1'b0, '0},
		'{{CMD_SECOND, 16'h8000, 8'd0, 1'b1}, 1, 1'b1,
			{38'sd68719476736, 9'd0, 1'b1, 1'b1}}
	};

	sparse_polynomial_multiply dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.term_valid   (term_valid),
		.term_ready   (term_ready),
		.term         (term),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	function automatic void predict_product(input spm_pkg::term_beat_t t, input bit keep);
		logic [spm_pkg::PEXP_W-1:0] exps[$];
		longint                     sums[$];
		longint                     prod;
		logic [spm_pkg::PEXP_W-1:0] e;
		int                         slot;
		int                         nonzero;
		int                         emitted;
		spm_pkg::result_beat_t      r;
		if (t.cmd == CMD_FIRST) begin
			if (first_n < TERM_CAP) begin
				first_terms[first_n] = {t.coefficient, t.exponent};
				first_n++;
				counted_beats++;
			end
			return;
		end
		if (second_n < TERM_CAP) begin
			second_terms[second_n] = {t.coefficient, t.exponent};
			second_n++;
			counted_beats++;
		end else if (t.last_term) begin
			counted_beats++;
		end
		if (!t.last_term) begin
			return;
		end
		for (int i = 0; i < first_n; i++) begin
			for (int j = 0; j < second_n; j++) begin
				prod = longint'($signed(first_terms[i].coefficient)) *
					longint'($signed(second_terms[j].coefficient));
				e = {1'b0, first_terms[i].exponent} + {1'b0, second_terms[j].exponent};
				slot = -1;
				for (int k = 0; k < exps.size(); k++) begin
					if (slot < 0 && exps[k] == e) begin
						slot = k;
					end
				end
				if (slot < 0) begin
					exps.insert(exps.size(), e);
					sums.insert(sums.size(), prod);
				end else begin
					sums[slot] += prod;
				end
			end
		end
		nonzero = 0;
		foreach (sums[k]) begin
			if (sums[k] != 0) begin
				nonzero++;
			end
		end
		emitted = 0;
		if (nonzero == 0) begin
			r = {38'sd0, 9'd0, 1'b0, 1'b1};
			if (keep) begin
				product_due.insert(product_due.size(), r);
			end
		end else begin
			foreach (sums[k]) begin
				if (sums[k] != 0) begin
					emitted++;
					r.product_coefficient = sums[k][spm_pkg::SUM_W-1:0];
					r.product_exponent    = exps[k];
					r.is_term             = 1'b1;
					r.last_result         = (emitted == nonzero);
					if (keep) begin
						product_due.insert(product_due.size(), r);
					end
				end
			end
		end
		first_n  = 0;
		second_n = 0;
	endfunction

	function automatic logic signed [spm_pkg::COEF_W-1:0] pick_coef(input int span);
		if (span == 0) begin
			return spm_pkg::COEF_W'($urandom_range(16'hFFFF));
		end
		return spm_pkg::COEF_W'($urandom_range(2 * span) - span);
	endfunction

	task automatic send_term(input spm_pkg::term_beat_t t, input bit typed,
		input spm_pkg::result_beat_t want);
		@(negedge clk);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			term_valid <= 1'b0;
			@(negedge clk);
		end
		term       <= t;
		term_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!term_ready);
		if (typed) begin
			product_due.insert(product_due.size(), want);
		end
		predict_product(t, !typed);
	endtask

	task automatic send_random_product();
		spm_pkg::term_beat_t beats[$];
		int         nf;
		int         ns;
		int         mode;
		int         span;
		int         base;
		logic signed [spm_pkg::COEF_W-1:0] c;
		logic [spm_pkg::EXP_W-1:0]         e;
		mode = $urandom_range(9);
		nf   = ($urandom_range(99) < 8) ? $urandom_range(8, 10) : $urandom_range(1, 4);
		ns   = ($urandom_range(99) < 8) ? $urandom_range(8, 10) : $urandom_range(1, 4);
		span = (mode >= 4 && mode <= 6) ? 3 : 0;
		base = $urandom_range(252);
		if (mode == 7) begin
			nf = nf + (nf % 2);
		end
		if (mode == 8) begin
			nf = 0;
		end
		for (int k = 0; k < nf; k++) begin
			if (mode == 7 && k % 2 == 1) begin
				c = -beats[k-1].coefficient;
				e = beats[k-1].exponent;
			end else begin
				c = pick_coef(span);
				e = (span != 0) ? spm_pkg::EXP_W'(base + $urandom_range(3)) :
					spm_pkg::EXP_W'($urandom_range(255));
			end
			beats.insert(beats.size(), {CMD_FIRST, c, e, 1'($urandom_range(1))});
		end
		for (int k = 0; k < ns; k++) begin
			if (mode == 9 && $urandom_range(3) == 0) begin
				beats.insert(beats.size(), {CMD_FIRST, pick_coef(0),
					spm_pkg::EXP_W'($urandom_range(255)), 1'($urandom_range(1))});
			end
			c = pick_coef(span);
			e = (span != 0) ? spm_pkg::EXP_W'(base + $urandom_range(3)) :
				spm_pkg::EXP_W'($urandom_range(255));
			beats.insert(beats.size(), {CMD_SECOND, c, e, 1'(k == ns - 1)});
		end
		foreach (beats[i]) begin
			send_term(beats[i], 1'b0, '0);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_results) begin
				hold_results = 1'b0;
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			result_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		spm_pkg::result_beat_t want;
		if (arst_n && result_valid && result_ready) begin
			if (product_due.size() == 0) begin
				$display("%0t: result beat with nothing expected: coef %0d exp %0d",
					$time, $signed(result.product_coefficient), result.product_exponent);
				errors++;
			end else begin
				want = product_due.pop_front();
				if (result.product_coefficient !== want.product_coefficient) begin
					$display("%0t: product_coefficient expected %0d got %0d", $time,
						$signed(want.product_coefficient), $signed(result.product_coefficient));
					errors++;
				end
				if (result.product_exponent !== want.product_exponent) begin
					$display("%0t: product_exponent expected %0d got %0d", $time,
						want.product_exponent, result.product_exponent);
					errors++;
				end
				if (result.is_term !== want.is_term) begin
					$display("%0t: is_term expected %0b got %0b", $time,
						want.is_term, result.is_term);
					errors++;
				end
				if (result.last_result !== want.last_result) begin
					$display("%0t: last_result expected %0b got %0b", $time,
						want.last_result, result.last_result);
					errors++;
				end
			end
		end
	end

	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((term_valid && term_ready) || (result_valid && result_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int pair;
		arst_n        = 1'b0;
		term_valid    = 1'b0;
		term          = '0;
		first_n       = 0;
		second_n      = 0;
		counted_beats = 0;
		errors        = 0;
		calm          = 1'b0;
		hold_results  = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (stim_table[n]) begin
			for (int r = 0; r < stim_table[n].reps; r++) begin
				send_term(stim_table[n].beat, stim_table[n].typed && r == stim_table[n].reps - 1,
					stim_table[n].want);
			end
		end

		counted_beats = 0;
		pair = 0;
		while (counted_beats < RANDOM_BEATS) begin
			if (pair == 4) begin
				hold_results = 1'b1;
			end
			calm = (pair >= 12 && pair < 18);
			if (pair % 9 == 7) begin
				@(negedge clk);
				term_valid <= 1'b0;
				while (product_due.size() != 0) @(negedge clk);
			end
			send_random_product();
			pair++;
		end

		@(negedge clk);
		term_valid <= 1'b0;
		while (product_due.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0 && product_due.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
